>>> rtl/assert_macros.svh
// assertion macros for the rtl files, included by psc_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

>>> rtl/psc_pkg.sv
// types, widths and constants of the pressure sensor conditioner
package psc_pkg;

   localparam int SAMPLES_PER_READING_DEF   = 10;
   localparam int AVERAGE_FRACTION_BITS_DEF = 8;

   localparam int ADC_W      = 12;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 4;
   localparam int MV_W       = 16;
   localparam int PRESS_W    = 11;
   localparam int OHM_W      = 20;
   localparam int SPAN_W     = 13;
   localparam int WEIGHT_W   = 9;
   localparam int SCALE_W    = 12;
   localparam int K_W        = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int ADC_FULL_CODE = 4095;
   localparam int ADC_FULL_MV   = 3300;
   localparam int WEIGHT_ONE    = 256;

   localparam int MV_Q_BITS = 16;
   localparam int P_Q_BITS  = 11;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIVIDER_TOP    = 3'd0,
      REG_DIVIDER_BOTTOM = 3'd1,
      REG_SPAN_LOW       = 3'd2,
      REG_SPAN_HIGH      = 3'd3,
      REG_FULL_SCALE     = 3'd4,
      REG_SMOOTHING      = 3'd5
   } psc_reg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_SCALE,
      OP_MUL_GAIN,
      OP_MUL_DEN,
      OP_DIV_MV_START,
      OP_MV_STORE,
      OP_MUL_SPAN,
      OP_DIV_P_START,
      OP_P_STORE,
      OP_ZERO_NOW,
      OP_MUL_DECAY,
      OP_EMA_UPDATE,
      OP_EMIT,
      OP_EMIT_ERR
   } psc_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_GAIN,
      ST_DEN,
      ST_DIV_MV_LOAD,
      ST_DIV_MV,
      ST_MV,
      ST_SPAN,
      ST_DIV_P_LOAD,
      ST_DIV_P,
      ST_PRESS,
      ST_DECAY,
      ST_EMA,
      ST_EMIT,
      ST_EMIT_ERR
   } psc_state_type;

   typedef struct packed {
      logic [OHM_W-1:0]    divider_top_ohms;
      logic [OHM_W-1:0]    divider_bottom_ohms;
      logic [SPAN_W-1:0]   span_low_mv;
      logic [SPAN_W-1:0]   span_high_mv;
      logic [PRESS_W-1:0]  full_scale_tenths;
      logic [WEIGHT_W-1:0] smoothing_weight;
   } psc_cfg_type;

   typedef struct packed {
      logic       take_sample;
      psc_op_type op;
   } psc_cmd_type;

   typedef struct packed {
      logic group_done;
      logic span_bad;
      logic mv_low;
      logic div_busy;
      logic out_free;
   } psc_stat_type;

endpackage

>>> rtl/psc_csr.sv
// configuration register file
module psc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [psc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output psc_pkg::psc_cfg_type               cfg
);

   psc_pkg::psc_cfg_type cfg_ff;
   psc_pkg::psc_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (psc_pkg::psc_reg_type'(csr_index))
            psc_pkg::REG_DIVIDER_TOP: begin
               cfg_in.divider_top_ohms = csr_wdata[psc_pkg::OHM_W-1:0];
            end
            psc_pkg::REG_DIVIDER_BOTTOM: begin
               cfg_in.divider_bottom_ohms = csr_wdata[psc_pkg::OHM_W-1:0];
            end
            psc_pkg::REG_SPAN_LOW: begin
               cfg_in.span_low_mv = csr_wdata[psc_pkg::SPAN_W-1:0];
            end
            psc_pkg::REG_SPAN_HIGH: begin
               cfg_in.span_high_mv = csr_wdata[psc_pkg::SPAN_W-1:0];
            end
            psc_pkg::REG_FULL_SCALE: begin
               cfg_in.full_scale_tenths = csr_wdata[psc_pkg::PRESS_W-1:0];
            end
            psc_pkg::REG_SMOOTHING: begin
               cfg_in.smoothing_weight = csr_wdata[psc_pkg::WEIGHT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_top_ohms    <= psc_pkg::OHM_W'(10000);
         cfg_ff.divider_bottom_ohms <= psc_pkg::OHM_W'(20000);
         cfg_ff.span_low_mv         <= psc_pkg::SPAN_W'(500);
         cfg_ff.span_high_mv        <= psc_pkg::SPAN_W'(4500);
         cfg_ff.full_scale_tenths   <= psc_pkg::PRESS_W'(1000);
         cfg_ff.smoothing_weight    <= psc_pkg::WEIGHT_W'(77);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/psc_div.sv
// restoring divider, one quotient bit per cycle
module psc_div #(
   parameter int DIV_W = 52,
   parameter int Q_W   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIV_W-1:0]              dividend,
   input  logic [DIV_W-1:0]              divisor,
   input  logic [psc_pkg::DIV_CNT_W-1:0] steps,
   output logic                          busy,
   output logic [Q_W-1:0]                quotient
);

   logic                          busy_ff, busy_in;
   logic [psc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]              rem_ff, rem_in;
   logic [DIV_W-1:0]              dsh_ff, dsh_in;
   logic [Q_W-1:0]                quo_ff, quo_in;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = dividend;
         dsh_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == psc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

endmodule

>>> rtl/psc_datapath.sv
// sample accumulation, shared multiplier, divider, moving average and result register
`include "assert_macros.svh"

module psc_datapath #(
   parameter int SAMPLES_PER_READING   = psc_pkg::SAMPLES_PER_READING_DEF,
   parameter int AVERAGE_FRACTION_BITS = psc_pkg::AVERAGE_FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  psc_pkg::psc_cfg_type             cfg,
   input  psc_pkg::psc_cmd_type             ctrl_cmd,
   output psc_pkg::psc_stat_type            ctrl_stat,
   input  logic                             req_valid,
   input  logic [psc_pkg::ADC_W-1:0]        req_adc_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [psc_pkg::PRESS_W-1:0]      rsp_pressure_now,
   output logic [psc_pkg::PRESS_W-1:0]      rsp_pressure_smoothed,
   output logic                             rsp_span_error
);

   localparam int SUM_W   = psc_pkg::SUM_W;
   localparam int CNT_W   = psc_pkg::CNT_W;
   localparam int MV_W    = psc_pkg::MV_W;
   localparam int PRESS_W = psc_pkg::PRESS_W;
   localparam int F       = AVERAGE_FRACTION_BITS;
   localparam int ACC_W   = PRESS_W + F;
   localparam int NUM0_W  = SUM_W + psc_pkg::SCALE_W;
   localparam int MA_W    = (NUM0_W > ACC_W) ? NUM0_W : ACC_W;
   localparam int MB_W    = psc_pkg::OHM_W + 1;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int DEN_W   = psc_pkg::K_W + psc_pkg::OHM_W;
   localparam int DSAT_W  = DEN_W + psc_pkg::MV_Q_BITS;
   localparam int DIV_W   = (PROD_W > DSAT_W) ? PROD_W : DSAT_W;
   localparam int EMA_W   = ACC_W + 10;
   localparam int WT_W    = psc_pkg::WEIGHT_W;
   localparam logic [psc_pkg::K_W-1:0] DEN_K =
      psc_pkg::K_W'(psc_pkg::ADC_FULL_CODE * SAMPLES_PER_READING);
   localparam logic [WT_W-1:0] WT_ONE = WT_W'(psc_pkg::WEIGHT_ONE);

   logic [SUM_W-1:0]   sample_sum_ff, sample_sum_in;
   logic [CNT_W-1:0]   sample_count_ff, sample_count_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SUM_W-1:0]   grp_sum_ff, grp_sum_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [MV_W-1:0]    mv_ff, mv_in;
   logic [PRESS_W-1:0] now_ff, now_in;
   logic               sat_ff, sat_in;
   logic [PRESS_W-1:0] rsp_now_ff, rsp_now_in;
   logic [PRESS_W-1:0] rsp_smooth_ff, rsp_smooth_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               accept;
   logic [SUM_W-1:0]   sum_next;
   logic [CNT_W-1:0]   count_next;
   logic               group_last;
   logic               out_free;
   logic               emit;

   logic [MA_W-1:0]    mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [PROD_W-1:0]  mult_p;
   logic [WT_W-1:0]    w_eff;
   logic [EMA_W-1:0]   ema_sum;
   logic [PRESS_W-1:0] q_press;

   logic               div_start;
   logic               div_busy;
   logic [DIV_W-1:0]   div_divisor;
   logic [DIV_W-1:0]   div_limit;
   logic [psc_pkg::DIV_CNT_W-1:0] div_steps;
   logic [psc_pkg::MV_Q_BITS-1:0] div_quo;

   assign accept     = req_valid && ctrl_cmd.take_sample;
   assign sum_next   = sample_sum_ff + SUM_W'(req_adc_sample);
   assign count_next = sample_count_ff + 1'b1;
   assign group_last = (count_next == CNT_W'(SAMPLES_PER_READING));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit       = ctrl_cmd.op inside {psc_pkg::OP_EMIT, psc_pkg::OP_EMIT_ERR};

   assign w_eff   = (cfg.smoothing_weight > WT_ONE) ? WT_ONE : cfg.smoothing_weight;
   assign q_press = div_quo[psc_pkg::P_Q_BITS-1:0];

   assign ctrl_stat.group_done = accept && group_last;
   assign ctrl_stat.span_bad   = (cfg.span_high_mv <= cfg.span_low_mv);
   assign ctrl_stat.mv_low     = (mv_ff <= MV_W'(cfg.span_low_mv));
   assign ctrl_stat.div_busy   = div_busy;
   assign ctrl_stat.out_free   = out_free;

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl_cmd.op)
         psc_pkg::OP_MUL_SCALE: begin
            mul_a = MA_W'(grp_sum_ff);
            mul_b = MB_W'(psc_pkg::ADC_FULL_MV);
         end
         psc_pkg::OP_MUL_GAIN: begin
            mul_a = MA_W'(prod_ff[NUM0_W-1:0]);
            mul_b = {1'b0, cfg.divider_top_ohms} + {1'b0, cfg.divider_bottom_ohms};
         end
         psc_pkg::OP_MUL_DEN: begin
            mul_a = MA_W'(DEN_K);
            mul_b = MB_W'(cfg.divider_bottom_ohms);
         end
         psc_pkg::OP_MUL_SPAN: begin
            mul_a = MA_W'(mv_ff - MV_W'(cfg.span_low_mv));
            mul_b = MB_W'(cfg.full_scale_tenths);
         end
         psc_pkg::OP_MUL_DECAY: begin
            mul_a = MA_W'(acc_ff);
            mul_b = MB_W'(WT_ONE - w_eff);
         end
         psc_pkg::OP_EMA_UPDATE: begin
            mul_a = MA_W'(now_ff);
            mul_b = MB_W'(w_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mult_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign ema_sum = EMA_W'(prod_ff) + (EMA_W'(mult_p) << F);

   assign div_start = ctrl_cmd.op inside {psc_pkg::OP_DIV_MV_START, psc_pkg::OP_DIV_P_START};

   always_comb begin
      if (ctrl_cmd.op == psc_pkg::OP_DIV_MV_START) begin
         div_divisor = DIV_W'(den_ff) << (psc_pkg::MV_Q_BITS - 1);
         div_limit   = DIV_W'(den_ff) << psc_pkg::MV_Q_BITS;
         div_steps   = psc_pkg::DIV_CNT_W'(psc_pkg::MV_Q_BITS);
      end else begin
         div_divisor = DIV_W'(den_ff) << (psc_pkg::P_Q_BITS - 1);
         div_limit   = DIV_W'(den_ff) << psc_pkg::P_Q_BITS;
         div_steps   = psc_pkg::DIV_CNT_W'(psc_pkg::P_Q_BITS);
      end
   end

   psc_div #(
      .DIV_W (DIV_W),
      .Q_W   (psc_pkg::MV_Q_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(prod_ff)),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      sample_sum_in   = sample_sum_ff;
      sample_count_in = sample_count_ff;
      grp_sum_in      = grp_sum_ff;
      prod_in         = prod_ff;
      den_in          = den_ff;
      mv_in           = mv_ff;
      now_in          = now_ff;
      sat_in          = sat_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_now_in      = rsp_now_ff;
      rsp_smooth_in   = rsp_smooth_ff;
      rsp_err_in      = rsp_err_ff;

      if (accept) begin
         if (group_last) begin
            grp_sum_in      = sum_next;
            sample_sum_in   = '0;
            sample_count_in = '0;
         end else begin
            sample_sum_in   = sum_next;
            sample_count_in = count_next;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (ctrl_cmd.op)
         psc_pkg::OP_MUL_SCALE, psc_pkg::OP_MUL_GAIN,
         psc_pkg::OP_MUL_DECAY: begin
            prod_in = mult_p;
         end
         psc_pkg::OP_MUL_DEN: begin
            den_in = mult_p[DEN_W-1:0];
         end
         psc_pkg::OP_DIV_MV_START, psc_pkg::OP_DIV_P_START: begin
            sat_in = (DIV_W'(prod_ff) >= div_limit);
         end
         psc_pkg::OP_MV_STORE: begin
            if (grp_sum_ff == '0) begin
               mv_in = '0;
            end else if (sat_ff) begin
               mv_in = '1;
            end else begin
               mv_in = div_quo[MV_W-1:0];
            end
         end
         psc_pkg::OP_MUL_SPAN: begin
            prod_in = mult_p;
            den_in  = DEN_W'(cfg.span_high_mv - cfg.span_low_mv);
         end
         psc_pkg::OP_P_STORE: begin
            if (sat_ff || (q_press > cfg.full_scale_tenths)) begin
               now_in = cfg.full_scale_tenths;
            end else begin
               now_in = q_press;
            end
         end
         psc_pkg::OP_ZERO_NOW: begin
            now_in = '0;
         end
         psc_pkg::OP_EMA_UPDATE: begin
            acc_in = ema_sum[ACC_W+7:8];
         end
         psc_pkg::OP_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_now_in    = now_ff;
            rsp_smooth_in = acc_ff[ACC_W-1:F];
            rsp_err_in    = 1'b0;
         end
         psc_pkg::OP_EMIT_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_now_in    = '0;
            rsp_smooth_in = '0;
            rsp_err_in    = 1'b1;
         end
         default: begin
            sat_in = sat_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_sum_ff   <= '0;
         sample_count_ff <= '0;
         acc_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sample_sum_ff   <= sample_sum_in;
         sample_count_ff <= sample_count_in;
         acc_ff          <= acc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_sum_ff    <= grp_sum_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      mv_ff         <= mv_in;
      now_ff        <= now_in;
      sat_ff        <= sat_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_smooth_ff <= rsp_smooth_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pressure_now      = rsp_now_ff;
   assign rsp_pressure_smoothed = rsp_smooth_ff;
   assign rsp_span_error        = rsp_err_ff;

   `ASSERT_CLK(a_count_below_group, clock, reset, sample_count_ff < SAMPLES_PER_READING)
   `ASSERT_CLK(a_press_clamped, clock, reset, (ctrl_cmd.op == psc_pkg::OP_P_STORE) |=> (now_ff <= cfg.full_scale_tenths))
   `ASSERT_NEVER(a_emit_over_pending, clock, reset, emit && rsp_valid_ff && !rsp_ready)
   `ASSERT_NEVER(a_div_restart, clock, reset, div_start && div_busy)

endmodule

>>> rtl/psc_ctrl.sv
// sequencing state machine for the conversion of one group
module psc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  psc_pkg::psc_stat_type ctrl_stat,
   output psc_pkg::psc_cmd_type  ctrl_cmd
);

   psc_pkg::psc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in             = state_ff;
      ctrl_cmd.take_sample = 1'b0;
      ctrl_cmd.op          = psc_pkg::OP_NONE;
      case (state_ff)
         psc_pkg::ST_IDLE: begin
            ctrl_cmd.take_sample = 1'b1;
            if (ctrl_stat.group_done) begin
               state_in = ctrl_stat.span_bad ? psc_pkg::ST_EMIT_ERR : psc_pkg::ST_SCALE;
            end
         end
         psc_pkg::ST_SCALE: begin
            ctrl_cmd.op = psc_pkg::OP_MUL_SCALE;
            state_in    = psc_pkg::ST_GAIN;
         end
         psc_pkg::ST_GAIN: begin
            ctrl_cmd.op = psc_pkg::OP_MUL_GAIN;
            state_in    = psc_pkg::ST_DEN;
         end
         psc_pkg::ST_DEN: begin
            ctrl_cmd.op = psc_pkg::OP_MUL_DEN;
            state_in    = psc_pkg::ST_DIV_MV_LOAD;
         end
         psc_pkg::ST_DIV_MV_LOAD: begin
            ctrl_cmd.op = psc_pkg::OP_DIV_MV_START;
            state_in    = psc_pkg::ST_DIV_MV;
         end
         psc_pkg::ST_DIV_MV: begin
            if (!ctrl_stat.div_busy) begin
               state_in = psc_pkg::ST_MV;
            end
         end
         psc_pkg::ST_MV: begin
            ctrl_cmd.op = psc_pkg::OP_MV_STORE;
            state_in    = psc_pkg::ST_SPAN;
         end
         psc_pkg::ST_SPAN: begin
            if (ctrl_stat.mv_low) begin
               ctrl_cmd.op = psc_pkg::OP_ZERO_NOW;
               state_in    = psc_pkg::ST_DECAY;
            end else begin
               ctrl_cmd.op = psc_pkg::OP_MUL_SPAN;
               state_in    = psc_pkg::ST_DIV_P_LOAD;
            end
         end
         psc_pkg::ST_DIV_P_LOAD: begin
            ctrl_cmd.op = psc_pkg::OP_DIV_P_START;
            state_in    = psc_pkg::ST_DIV_P;
         end
         psc_pkg::ST_DIV_P: begin
            if (!ctrl_stat.div_busy) begin
               state_in = psc_pkg::ST_PRESS;
            end
         end
         psc_pkg::ST_PRESS: begin
            ctrl_cmd.op = psc_pkg::OP_P_STORE;
            state_in    = psc_pkg::ST_DECAY;
         end
         psc_pkg::ST_DECAY: begin
            ctrl_cmd.op = psc_pkg::OP_MUL_DECAY;
            state_in    = psc_pkg::ST_EMA;
         end
         psc_pkg::ST_EMA: begin
            ctrl_cmd.op = psc_pkg::OP_EMA_UPDATE;
            state_in    = psc_pkg::ST_EMIT;
         end
         psc_pkg::ST_EMIT: begin
            if (ctrl_stat.out_free) begin
               ctrl_cmd.op = psc_pkg::OP_EMIT;
               state_in    = psc_pkg::ST_IDLE;
            end
         end
         psc_pkg::ST_EMIT_ERR: begin
            if (ctrl_stat.out_free) begin
               ctrl_cmd.op = psc_pkg::OP_EMIT_ERR;
               state_in    = psc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/pressure_sensor_conditioner.sv
// Pressure sensor conditioner: sums groups of SAMPLES_PER_READING 12-bit ADC samples and,
// on the last sample of each group, converts the average to millivolts, removes the input
// divider gain (saturating at 65535 mV), maps the sensor span onto 0..full_scale_tenths and
// updates a moving average with weight smoothing_weight/256; one response per group carries
// the reading, the smoothed reading and a span error flag. A sample that does not close a
// group is accepted without a stall. The sample that closes a group stalls the input until
// its response is issued, which also waits on rsp_ready for the previous one; a span error
// skips the conversion, a voltage at or below span_low_mv the pressure division. The serial
// restoring divider gives one quotient bit per cycle, 16 bits for the millivolt value and
// 11 for the pressure; the single shared multiplier serves six steps. Configuration registers
// should only be written while no group is in progress.
module pressure_sensor_conditioner #(
   parameter int SAMPLES_PER_READING   = psc_pkg::SAMPLES_PER_READING_DEF,
   parameter int AVERAGE_FRACTION_BITS = psc_pkg::AVERAGE_FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [psc_pkg::ADC_W-1:0]          req_adc_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psc_pkg::PRESS_W-1:0]        rsp_pressure_now,
   output logic [psc_pkg::PRESS_W-1:0]        rsp_pressure_smoothed,
   output logic                               rsp_span_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [psc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   psc_pkg::psc_cfg_type  cfg;
   psc_pkg::psc_cmd_type  ctrl_cmd;
   psc_pkg::psc_stat_type ctrl_stat;

   assign req_ready = ctrl_cmd.take_sample;

   psc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .ctrl_stat (ctrl_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   psc_datapath #(
      .SAMPLES_PER_READING   (SAMPLES_PER_READING),
      .AVERAGE_FRACTION_BITS (AVERAGE_FRACTION_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .ctrl_cmd              (ctrl_cmd),
      .ctrl_stat             (ctrl_stat),
      .req_valid             (req_valid),
      .req_adc_sample        (req_adc_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pressure_now      (rsp_pressure_now),
      .rsp_pressure_smoothed (rsp_pressure_smoothed),
      .rsp_span_error        (rsp_span_error)
   );

endmodule

>>> test/tb_pressure_sensor_conditioner.sv
// testbench of the pressure sensor conditioner: directed and random groups against a predictor
module tb_pressure_sensor_conditioner;

   localparam int SAMPLES       = psc_pkg::SAMPLES_PER_READING_DEF;
   localparam int FRAC_BITS     = psc_pkg::AVERAGE_FRACTION_BITS_DEF;
   localparam int ACC_W         = psc_pkg::PRESS_W + FRAC_BITS;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 15;
   localparam int QUIET_PHASES  = 3;
   localparam int PHASE_GROUPS  = 6;

   localparam logic [psc_pkg::CSR_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
   localparam logic [psc_pkg::CSR_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

   typedef enum {GRP_CONST, GRP_NOISY, GRP_RANDOM} group_kind_type;

   typedef struct {
      logic [psc_pkg::PRESS_W-1:0] tenths_now;
      logic [psc_pkg::PRESS_W-1:0] tenths_smoothed;
      logic                        span_error;
   } pressure_reading_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [psc_pkg::ADC_W-1:0]      req_adc_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [psc_pkg::PRESS_W-1:0]    rsp_pressure_now;
   logic [psc_pkg::PRESS_W-1:0]    rsp_pressure_smoothed;
   logic                           rsp_span_error;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [psc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [psc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   psc_pkg::psc_cfg_type          cfg;
   logic [psc_pkg::SUM_W-1:0]     group_sum;
   logic [psc_pkg::CNT_W-1:0]     group_count;
   logic [ACC_W-1:0]              ema_acc;
   pressure_reading_type          expected_readings[$];

   bit idle_on = 1'b1;
   bit samples_since_idle = 1'b0;
   int fail_count = 0;
   int cycle_count = 0;

   pressure_sensor_conditioner #(
      .SAMPLES_PER_READING  (SAMPLES),
      .AVERAGE_FRACTION_BITS(FRAC_BITS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_adc_sample       (req_adc_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pressure_now     (rsp_pressure_now),
      .rsp_pressure_smoothed(rsp_pressure_smoothed),
      .rsp_span_error       (rsp_span_error),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [psc_pkg::MV_W-1:0] divider_millivolts(
      input logic [psc_pkg::SUM_W-1:0] sum);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] mv;
      if (sum == '0) return '0;
      if (cfg.divider_bottom_ohms == '0) return '1;
      num = 64'(sum) * 64'(psc_pkg::ADC_FULL_MV)
            * (64'(cfg.divider_top_ohms) + 64'(cfg.divider_bottom_ohms));
      den = 64'(psc_pkg::ADC_FULL_CODE) * 64'(SAMPLES) * 64'(cfg.divider_bottom_ohms);
      mv = num / den;
      return (mv > 64'hFFFF) ? '1 : mv[psc_pkg::MV_W-1:0];
   endfunction

   function automatic logic [psc_pkg::PRESS_W-1:0] span_tenths(
      input logic [psc_pkg::MV_W-1:0] mv);
      logic [63:0] p;
      if (64'(mv) <= 64'(cfg.span_low_mv)) return '0;
      p = (64'(mv) - 64'(cfg.span_low_mv)) * 64'(cfg.full_scale_tenths)
          / (64'(cfg.span_high_mv) - 64'(cfg.span_low_mv));
      return (p > 64'(cfg.full_scale_tenths)) ? cfg.full_scale_tenths
                                              : p[psc_pkg::PRESS_W-1:0];
   endfunction

   task automatic accumulate_sample(input logic [psc_pkg::ADC_W-1:0] adc);
      pressure_reading_type      r;
      logic [psc_pkg::SUM_W-1:0] sum;
      logic [63:0]               w;
      logic [63:0]               acc;
      group_sum = group_sum + psc_pkg::SUM_W'(adc);
      group_count = group_count + 1'b1;
      if (group_count < psc_pkg::CNT_W'(SAMPLES)) return;
      sum = group_sum;
      group_sum = '0;
      group_count = '0;
      if (cfg.span_high_mv <= cfg.span_low_mv) begin
         r.tenths_now = '0;
         r.tenths_smoothed = '0;
         r.span_error = 1'b1;
      end else begin
         r.tenths_now = span_tenths(divider_millivolts(sum));
         w = (cfg.smoothing_weight > psc_pkg::WEIGHT_ONE) ? 64'(psc_pkg::WEIGHT_ONE)
                                                          : 64'(cfg.smoothing_weight);
         acc = (64'(ema_acc) * (64'(psc_pkg::WEIGHT_ONE) - w)
                + (64'(r.tenths_now) << FRAC_BITS) * w) >> 8;
         ema_acc = acc[ACC_W-1:0];
         r.tenths_smoothed = ema_acc[ACC_W-1:FRAC_BITS];
         r.span_error = 1'b0;
      end
      expected_readings.push_back(r);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic check_reading();
      pressure_reading_type r;
      if (expected_readings.size() == 0) begin
         report_mismatch("response with no request pending");
         return;
      end
      r = expected_readings.pop_front();
      if (rsp_pressure_now !== r.tenths_now)
         report_mismatch($sformatf("pressure_now %0d, expected %0d",
                                   rsp_pressure_now, r.tenths_now));
      if (rsp_pressure_smoothed !== r.tenths_smoothed)
         report_mismatch($sformatf("pressure_smoothed %0d, expected %0d",
                                   rsp_pressure_smoothed, r.tenths_smoothed));
      if (rsp_span_error !== r.span_error)
         report_mismatch($sformatf("span_error %0b, expected %0b",
                                   rsp_span_error, r.span_error));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) check_reading();
   end

   // response side backpressure
   initial begin : ready_drive
      int hold;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ready = 1'b0;
            hold = $urandom_range(1, 15);
            repeat (hold) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   task automatic settle();
      while (expected_readings.size() != 0) @(posedge clock);
      if (samples_since_idle) repeat (DRAIN_CYCLES) @(posedge clock);
      samples_since_idle = 1'b0;
   endtask

   task automatic write_register(input logic [psc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [psc_pkg::CSR_DATA_W-1:0] data);
      settle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         psc_pkg::REG_DIVIDER_TOP:
            cfg.divider_top_ohms = data[psc_pkg::OHM_W-1:0];
         psc_pkg::REG_DIVIDER_BOTTOM:
            cfg.divider_bottom_ohms = data[psc_pkg::OHM_W-1:0];
         psc_pkg::REG_SPAN_LOW:
            cfg.span_low_mv = data[psc_pkg::SPAN_W-1:0];
         psc_pkg::REG_SPAN_HIGH:
            cfg.span_high_mv = data[psc_pkg::SPAN_W-1:0];
         psc_pkg::REG_FULL_SCALE:
            cfg.full_scale_tenths = data[psc_pkg::PRESS_W-1:0];
         psc_pkg::REG_SMOOTHING:
            cfg.smoothing_weight = data[psc_pkg::WEIGHT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_sample(input logic [psc_pkg::ADC_W-1:0] adc);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_adc_sample = adc;
      do @(posedge clock); while (req_ready !== 1'b1);
      samples_since_idle = 1'b1;
      accumulate_sample(adc);
   endtask

   task automatic send_group(input group_kind_type kind, input int level);
      int v;
      for (int i = 0; i < SAMPLES; i++) begin
         case (kind)
            GRP_CONST: v = level;
            GRP_NOISY: v = level + int'($urandom_range(0, 128)) - 64;
            default:   v = int'($urandom_range(0, 4095));
         endcase
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         send_sample(psc_pkg::ADC_W'(v));
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_settings(input logic [19:0] top, input logic [19:0] bottom,
                                 input logic [12:0] lo, input logic [12:0] hi,
                                 input logic [10:0] full, input logic [8:0] wt);
      write_register(psc_pkg::REG_DIVIDER_TOP, top);
      write_register(psc_pkg::REG_DIVIDER_BOTTOM, bottom);
      write_register(psc_pkg::REG_SPAN_LOW, 20'(lo));
      write_register(psc_pkg::REG_SPAN_HIGH, 20'(hi));
      write_register(psc_pkg::REG_FULL_SCALE, 20'(full));
      write_register(psc_pkg::REG_SMOOTHING, 20'(wt));
   endtask

   task automatic test_default_scaling();
      send_group(GRP_CONST, 0);
      send_group(GRP_CONST, 4095);
      send_group(GRP_CONST, 2048);
   endtask

   task automatic test_span_error();
      write_register(psc_pkg::REG_SPAN_LOW, 20'd2000);
      write_register(psc_pkg::REG_SPAN_HIGH, 20'd2000);
      send_group(GRP_CONST, 3000);
      write_register(psc_pkg::REG_SPAN_LOW, 20'd5000);
      write_register(psc_pkg::REG_SPAN_HIGH, 20'd0);
      send_group(GRP_RANDOM, 0);
      write_settings(20'd10000, 20'd20000, 13'd500, 13'd4500, 11'd1000, 9'd77);
      send_group(GRP_CONST, 2500);
   endtask

   task automatic test_zero_bottom_resistor();
      write_register(psc_pkg::REG_DIVIDER_BOTTOM, 20'd0);
      write_register(psc_pkg::REG_SPAN_HIGH, 20'h1FFF);
      write_register(psc_pkg::REG_FULL_SCALE, 20'h7FF);
      send_group(GRP_CONST, 0);
      send_group(GRP_CONST, 1);
      write_settings(20'd10000, 20'd20000, 13'd500, 13'd4500, 11'd1000, 9'd77);
   endtask

   task automatic test_weight_limits();
      write_register(psc_pkg::REG_SMOOTHING, 20'h1FF);
      send_group(GRP_CONST, 3000);
      write_register(psc_pkg::REG_SMOOTHING, 20'd0);
      send_group(GRP_CONST, 1000);
      write_register(psc_pkg::REG_SMOOTHING, 20'd256);
      send_group(GRP_CONST, 1500);
      write_register(psc_pkg::REG_SMOOTHING, 20'd3);
      send_group(GRP_CONST, 4095);
   endtask

   task automatic test_unused_index();
      write_register(IDX_UNUSED_LO, 20'hFFFFF);
      write_register(IDX_UNUSED_HI, 20'h00000);
      send_group(GRP_NOISY, 2048);
      write_settings(20'hFFFFF, 20'hFFFFF, 13'd0, 13'h1FFF, 11'h7FF, 9'h1FF);
      send_group(GRP_CONST, 4095);
      write_settings(20'd0, 20'd1, 13'd0, 13'd1, 11'd0, 9'd3);
      send_group(GRP_CONST, 1);
   endtask

   task automatic random_settings();
      int mode;
      logic [19:0] top;
      logic [19:0] bottom;
      logic [12:0] lo;
      logic [12:0] hi;
      logic [10:0] full;
      logic [8:0]  wt;
      mode = $urandom_range(0, 11);
      top = 20'($urandom_range(0, 60000));
      bottom = 20'($urandom_range(5000, 1000000));
      lo = 13'($urandom_range(0, 4000));
      hi = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, lo))
                                       : 13'($urandom_range(lo + 1, 5000));
      full = 11'($urandom_range(0, 2000));
      wt = 9'($urandom_range(3, 256));
      case (mode)
         0: begin
            top = 20'hFFFFF; bottom = 20'hFFFFF; lo = 13'd0; hi = 13'h1FFF;
            full = 11'h7FF; wt = 9'h1FF;
         end
         1: begin
            top = 20'd0; bottom = 20'd1; lo = 13'd0; hi = 13'd1; full = 11'd2000; wt = 9'd0;
         end
         2: begin
            top = 20'd1000000; bottom = 20'd1000000; lo = 13'd5000; hi = 13'd5000;
         end
         3: bottom = 20'd0;
         4: top = 20'($urandom_range(0, 1000000));
         default: ;
      endcase
      write_settings(top, bottom, lo, hi, full, wt);
      if ($urandom_range(0, 3) == 0)
         write_register(($urandom_range(0, 1) != 0) ? IDX_UNUSED_HI : IDX_UNUSED_LO,
                        20'($urandom));
   endtask

   task automatic test_random_phases(input int phases, input bit idle);
      int kind;
      idle_on = idle;
      for (int p = 0; p < phases; p++) begin
         random_settings();
         for (int g = 0; g < PHASE_GROUPS; g++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) send_group(GRP_RANDOM, 0);
            else if (kind < 6) send_group(GRP_NOISY, $urandom_range(0, 4095));
            else send_group(GRP_CONST, $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      cfg.divider_top_ohms = 20'd10000;
      cfg.divider_bottom_ohms = 20'd20000;
      cfg.span_low_mv = 13'd500;
      cfg.span_high_mv = 13'd4500;
      cfg.full_scale_tenths = 11'd1000;
      cfg.smoothing_weight = 9'd77;
      group_sum = '0;
      group_count = '0;
      ema_acc = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_scaling();
      test_span_error();
      test_zero_bottom_resistor();
      test_weight_limits();
      test_unused_index();
      test_random_phases(RANDOM_PHASES - QUIET_PHASES, 1'b1);
      test_random_phases(QUIET_PHASES, 1'b0);

      samples_since_idle = 1'b1;
      settle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_csr.sv
rtl/psc_div.sv
rtl/psc_datapath.sv
rtl/psc_ctrl.sv
rtl/pressure_sensor_conditioner.sv
test/tb_pressure_sensor_conditioner.sv
